// ----- rtl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Lane numbering and the control bundle shared by the pipeline cells.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // Each cell carries three independent divisions side by side.
  localparam int NUM_LANES  = 3;
  localparam int LANE_LIGHT = 0;
  localparam int LANE_SAT   = 1;
  localparam int LANE_HUE   = 2;

  // Control that moves from one stage to the next with the data.
  typedef struct packed {
    logic valid;   // Stage holds a pixel.
    logic chroma;  // Pixel has color: hue and saturation are meaningful.
  } cell_ctl_t;

endpackage

// ----- rtl/rhc_prep.sv -----
// ----------------------------------------------------------------------------
// RGB to HSL front stage
// Finds max, min and delta of a pixel and sets up the numerator and
// denominator of the lightness, saturation and hue divisions.
// ----------------------------------------------------------------------------
module rhc_prep #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [CHANNEL_BITS-1:0]                      red,
  input  logic [CHANNEL_BITS-1:0]                      green,
  input  logic [CHANNEL_BITS-1:0]                      blue,
  input  logic [CHANNEL_BITS-1:0]                      alpha,
  output rhc_pkg::cell_ctl_t                           out_ctl,
  input  logic                                         out_ready,
  output logic [rhc_pkg::NUM_LANES-1:0][CHANNEL_BITS+3:0] out_rem,
  output logic [rhc_pkg::NUM_LANES-1:0][CHANNEL_BITS+3:0] out_den,
  output logic [CHANNEL_BITS-1:0]                      out_alpha
);
  import rhc_pkg::*;

  localparam int W      = CHANNEL_BITS + 4;
  localparam int CH_MAX = 2**CHANNEL_BITS - 1;

  logic [CHANNEL_BITS-1:0]             hi, lo, delta;
  logic [CHANNEL_BITS:0]               sum, sat_den;
  logic [W-1:0]                        delta2, delta4, den6, hue_num;
  logic                                chroma_in;
  logic                                valid;
  logic                                chroma;
  logic [NUM_LANES-1:0][W-1:0]         rem;
  logic [NUM_LANES-1:0][W-1:0]         den;
  logic [CHANNEL_BITS-1:0]             alpha_q;

  // Max and min; ties for the max go to red, then green.
  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    delta     = hi - lo;
    sum       = (CHANNEL_BITS+1)'(hi) + (CHANNEL_BITS+1)'(lo);
    chroma_in = (hi != '0) && (delta != '0);
  end

  // Saturation denominator depends on which half lightness falls in.
  always_comb begin
    if (sum < (CHANNEL_BITS+1)'(CH_MAX)) begin
      sat_den = sum;
    end else begin
      sat_den = (CHANNEL_BITS+1)'(2 * CH_MAX) - sum;
    end
  end

  // Hue numerator over 6 * delta, already wrapped into [0, 6 * delta).
  always_comb begin
    delta2 = W'(delta) << 1;
    delta4 = W'(delta) << 2;
    den6   = delta4 + delta2;
    if (red == hi) begin
      if (green >= blue) begin
        hue_num = W'(green - blue);
      end else begin
        hue_num = den6 - W'(blue - green);
      end
    end else if (green == hi) begin
      hue_num = delta2 + W'(blue) - W'(red);
    end else begin
      hue_num = delta4 + W'(red) - W'(green);
    end
  end

  assign in_ready = !valid || out_ready;

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      chroma              <= chroma_in;
      rem[LANE_LIGHT]     <= W'(sum);
      den[LANE_LIGHT]     <= W'(2 * CH_MAX);
      rem[LANE_SAT]       <= W'(delta);
      den[LANE_SAT]       <= W'(sat_den);
      rem[LANE_HUE]       <= hue_num;
      den[LANE_HUE]       <= den6;
      alpha_q             <= alpha;
    end
  end

  assign out_ctl.valid  = valid;
  assign out_ctl.chroma = chroma;
  assign out_rem        = rem;
  assign out_den        = den;
  assign out_alpha      = alpha_q;

endmodule

// ----- rtl/rhc_div_cell.sv -----
// ----------------------------------------------------------------------------
// RGB to HSL division cell
// One restoring division step on each of the three lanes; a row of these
// cells develops one quotient bit per cell, most significant bit first.
// ----------------------------------------------------------------------------
module rhc_div_cell #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  rhc_pkg::cell_ctl_t                               in_ctl,
  output logic                                             in_ready,
  input  logic [rhc_pkg::NUM_LANES-1:0][CHANNEL_BITS+3:0]  in_rem,
  input  logic [rhc_pkg::NUM_LANES-1:0][CHANNEL_BITS+3:0]  in_den,
  input  logic [rhc_pkg::NUM_LANES-1:0][FRACTION_BITS-1:0] in_quo,
  input  logic [CHANNEL_BITS-1:0]                          in_alpha,
  output rhc_pkg::cell_ctl_t                               out_ctl,
  input  logic                                             out_ready,
  output logic [rhc_pkg::NUM_LANES-1:0][CHANNEL_BITS+3:0]  out_rem,
  output logic [rhc_pkg::NUM_LANES-1:0][CHANNEL_BITS+3:0]  out_den,
  output logic [rhc_pkg::NUM_LANES-1:0][FRACTION_BITS-1:0] out_quo,
  output logic [CHANNEL_BITS-1:0]                          out_alpha
);
  import rhc_pkg::*;

  localparam int W = CHANNEL_BITS + 4;

  logic [NUM_LANES-1:0][W-1:0]             rem_next;
  logic [NUM_LANES-1:0][FRACTION_BITS-1:0] quo_next;
  logic [NUM_LANES-1:0][W-1:0]             rem;
  logic [NUM_LANES-1:0][W-1:0]             den;
  logic [NUM_LANES-1:0][FRACTION_BITS-1:0] quo;
  logic [CHANNEL_BITS-1:0]                 alpha_q;
  logic                                    valid;
  logic                                    chroma;

  // Shift the partial remainder and subtract the divisor when it fits.
  // The remainder never exceeds the divisor, so a numerator equal to the
  // divisor yields all ones, which is the saturated value of 1.0.
  always_comb begin
    logic [W-1:0] rem2;
    logic         fits;
    for (int i = 0; i < NUM_LANES; i++) begin
      rem2        = {in_rem[i][W-2:0], 1'b0};
      fits        = rem2 >= in_den[i];
      rem_next[i] = fits ? rem2 - in_den[i] : rem2;
      quo_next[i] = {in_quo[i][FRACTION_BITS-2:0], fits};
    end
  end

  assign in_ready = !valid || out_ready;

  // Cell valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_ctl.valid;
    end
  end

  // Cell payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_ctl.valid) begin
      chroma  <= in_ctl.chroma;
      rem     <= rem_next;
      den     <= in_den;
      quo     <= quo_next;
      alpha_q <= in_alpha;
    end
  end

  assign out_ctl.valid  = valid;
  assign out_ctl.chroma = chroma;
  assign out_rem        = rem;
  assign out_den        = den;
  assign out_quo        = quo;
  assign out_alpha      = alpha_q;

endmodule

// ----- rtl/rgb_to_hsl_converter_core.sv -----
// ----------------------------------------------------------------------------
// RGB to HSL converter core
// Converts an RGBA pixel stream to hue, saturation, lightness and alpha.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock while the output is not stalled and
// returns one HSL result per pixel, in order. It has one front stage that
// finds max, min and delta, then a row of FRACTION_BITS division cells, each
// producing one quotient bit for the lightness, saturation and hue divisions
// at once. Every stage holds its own valid bit, so bubbles close up and new
// pixels are taken while a finished result waits on the output. Results are
// truncated Q0.FRACTION_BITS fractions; lightness and saturation of 1.0 read
// as all ones, and grey or black pixels give zero hue and saturation.
module rgb_to_hsl_converter_core #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  // red_in, green_in, blue_in, alpha_in, zero padding
  input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0]             s_tdata,
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  // hue_out, saturation_out, lightness_out, alpha_out, zero padding
  output logic [((3*FRACTION_BITS+CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);
  import rhc_pkg::*;

  localparam int W      = CHANNEL_BITS + 4;
  localparam int OUT_W  = ((3*FRACTION_BITS+CHANNEL_BITS+7)/8)*8;
  localparam int STAGES = FRACTION_BITS + 1;

  cell_ctl_t                               st_ctl   [STAGES];
  logic                                    st_ready [STAGES];
  logic [NUM_LANES-1:0][W-1:0]             st_rem   [STAGES];
  logic [NUM_LANES-1:0][W-1:0]             st_den   [STAGES];
  logic [NUM_LANES-1:0][FRACTION_BITS-1:0] st_quo   [STAGES];
  logic [CHANNEL_BITS-1:0]                 st_alpha [STAGES];
  logic [FRACTION_BITS-1:0]                hue, sat, light;

  // Front stage.
  rhc_prep #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .red      (s_tdata[0*CHANNEL_BITS +: CHANNEL_BITS]),
    .green    (s_tdata[1*CHANNEL_BITS +: CHANNEL_BITS]),
    .blue     (s_tdata[2*CHANNEL_BITS +: CHANNEL_BITS]),
    .alpha    (s_tdata[3*CHANNEL_BITS +: CHANNEL_BITS]),
    .out_ctl  (st_ctl[0]),
    .out_ready(st_ready[0]),
    .out_rem  (st_rem[0]),
    .out_den  (st_den[0]),
    .out_alpha(st_alpha[0])
  );

  // The quotient starts empty and fills one bit per cell.
  assign st_quo[0] = '0;

  // Row of division cells.
  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_cell
    rhc_div_cell #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctl   (st_ctl[k]),
      .in_ready (st_ready[k]),
      .in_rem   (st_rem[k]),
      .in_den   (st_den[k]),
      .in_quo   (st_quo[k]),
      .in_alpha (st_alpha[k]),
      .out_ctl  (st_ctl[k+1]),
      .out_ready(st_ready[k+1]),
      .out_rem  (st_rem[k+1]),
      .out_den  (st_den[k+1]),
      .out_quo  (st_quo[k+1]),
      .out_alpha(st_alpha[k+1])
    );
  end

  // The last cell register is the output register.
  assign st_ready[STAGES-1] = m_tready;
  assign m_tvalid           = st_ctl[STAGES-1].valid;

  // Hue and saturation are zero for pixels without color.
  assign light = st_quo[STAGES-1][LANE_LIGHT];
  assign sat   = st_ctl[STAGES-1].chroma ? st_quo[STAGES-1][LANE_SAT] : '0;
  assign hue   = st_ctl[STAGES-1].chroma ? st_quo[STAGES-1][LANE_HUE] : '0;

  assign m_tdata = OUT_W'({st_alpha[STAGES-1], light, sat, hue});

endmodule

// ----- rtl/rhc_checker.sv -----
// ----------------------------------------------------------------------------
// RGB to HSL converter assertions
// Port-level assertions on the converter core, attached by a bind statement.
// ----------------------------------------------------------------------------
module rhc_assertions #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input logic                                              clk,
  input logic                                              rst,
  input logic                                              s_tvalid,
  input logic                                              s_tready,
  input logic                                              m_tvalid,
  input logic                                              m_tready,
  input logic [((3*FRACTION_BITS+CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);

  localparam int F = FRACTION_BITS;

  logic [F-1:0] hue, sat;
  logic         fine_sat;

  assign hue      = m_tdata[0 +: F];
  assign sat      = m_tdata[F +: F];
  assign fine_sat = FRACTION_BITS > CHANNEL_BITS;

  // Nothing is offered on the output right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

  // The input is refused only when the whole pipe is backed up by the output.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused without output backpressure");

  // With more fraction bits than channel bits, a pixel without saturation is grey or black and has zero hue.
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && fine_sat && sat == '0 |-> hue == '0)
    else $error("nonzero hue with zero saturation");

  // A pixel offered while the output side is ready is always taken.
  a_in_taken: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && m_tready |-> s_tready)
    else $error("pixel refused while the output was ready");

endmodule

bind rgb_to_hsl_converter_core rhc_assertions #(
  .CHANNEL_BITS (CHANNEL_BITS),
  .FRACTION_BITS(FRACTION_BITS)
) u_rhc_assertions (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ----- tb/rhc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter checker
// Watches both stream channels of the converter, works out the HSL result of
// every pixel that goes in and compares it, field by field, with what comes
// out, in order.
// ----------------------------------------------------------------------------
module rhc_checker #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              s_tvalid,
  input  logic                                              s_tready,
  // red_in, green_in, blue_in, alpha_in, zero padding
  input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0]               s_tdata,
  input  logic                                              m_tvalid,
  input  logic                                              m_tready,
  // hue_out, saturation_out, lightness_out, alpha_out, zero padding
  input  logic [((3*FRACTION_BITS+CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
  output int                                                failures,
  output int                                                pending,
  output int                                                results
);

  localparam int F = FRACTION_BITS;
  localparam int C = CHANNEL_BITS;
  localparam longint CH_FULL = (64'd1 << C) - 1;
  localparam longint FR_FULL = (64'd1 << F) - 1;

  typedef struct packed {
    logic [F-1:0] hue;
    logic [F-1:0] sat;
    logic [F-1:0] light;
    logic [C-1:0] alpha;
  } hsl_pixel_t;

  // Results still owed by the converter, oldest first.
  hsl_pixel_t hsl_owed_q [$];
  int         mismatch_cnt = 0;
  int         result_cnt   = 0;

  assign failures = mismatch_cnt;
  assign results  = result_cnt;

  // Truncated fraction num/den in Q0.F, where 1.0 reads as all ones.
  function automatic longint frac_quot(input longint num, input longint den);
    longint q;
    if (den == 0) return 0;
    q = (num << F) / den;
    return (q > FR_FULL) ? FR_FULL : q;
  endfunction

  // Expected HSL result of one RGBA pixel.
  function automatic hsl_pixel_t hsl_of_pixel(input logic [4*C-1:0] pix);
    hsl_pixel_t res;
    longint     r, g, b, hi, lo, delta, sum, angle, sextant6, hue;
    r   = longint'(pix[C-1:0]);
    g   = longint'(pix[2*C-1:C]);
    b   = longint'(pix[3*C-1:2*C]);
    hi  = r;
    lo  = r;
    hue = 0;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    sum   = hi + lo;

    res.light = F'(frac_quot(sum, 2 * CH_FULL));
    res.alpha = pix[4*C-1:3*C];
    res.sat   = '0;

    // Black and grey pixels carry no hue and no saturation.
    if (hi != 0 && delta != 0) begin
      if (sum < CH_FULL) begin
        res.sat = F'(frac_quot(delta, sum));
      end else begin
        res.sat = F'(frac_quot(delta, 2 * CH_FULL - sum));
      end

      // Sextant formula; on ties red wins over green, green over blue.
      sextant6 = 6 * delta;
      if (r == hi) begin
        angle = g - b;
      end else if (g == hi) begin
        angle = 2 * delta + b - r;
      end else begin
        angle = 4 * delta + r - g;
      end
      if (angle < 0) angle += sextant6;
      hue = (angle << F) / sextant6;
      if (hue > FR_FULL) hue = FR_FULL;
    end
    res.hue = F'(hue);
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Record every pixel transfer and check every result transfer.
  always @(posedge clk) begin : watch
    hsl_pixel_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) hsl_owed_q.push_back(hsl_of_pixel(s_tdata[4*C-1:0]));
      if (m_tvalid && m_tready) begin
        if (hsl_owed_q.size() == 0) begin
          $error("result transfer with no pixel outstanding: m_tdata = %h", m_tdata);
          mismatch_cnt++;
        end else begin
          want      = hsl_owed_q.pop_front();
          got.hue   = m_tdata[F-1:0];
          got.sat   = m_tdata[2*F-1:F];
          got.light = m_tdata[3*F-1:2*F];
          got.alpha = m_tdata[3*F+C-1:3*F];
          check_field("hue_out", longint'(want.hue), longint'(got.hue));
          check_field("saturation_out", longint'(want.sat), longint'(got.sat));
          check_field("lightness_out", longint'(want.light), longint'(got.light));
          check_field("alpha_out", longint'(want.alpha), longint'(got.alpha));
          result_cnt++;
        end
      end
    end
    pending <= hsl_owed_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Feeds corner colors and then random pixels in bursts, while the output side
// stalls at random and once holds off long enough to back the pipeline up.
// The checker beside the converter predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;
  localparam int IN_W          = ((4*CHANNEL_BITS+7)/8)*8;
  localparam int OUT_W         = ((3*FRACTION_BITS+CHANNEL_BITS+7)/8)*8;
  localparam int RANDOM_PIXELS = 1000;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 400;

  typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARE} ready_mode_t;
  typedef enum int {PIX_ANY, PIX_GREY, PIX_TIE_RG, PIX_TIE_GB, PIX_TIE_RB, PIX_EXTREME}
    pixel_kind_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  int failures;
  int pending;
  int results;
  int pixels_sent = 0;
  bit hold_done   = 1'b0;

  always #5 clk = ~clk;

  rgb_to_hsl_converter_core #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  rhc_checker #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .failures(failures),
    .pending (pending),
    .results (results)
  );

  function automatic logic [IN_W-1:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b, input logic [7:0] a);
    return {a, b, g, r};
  endfunction

  // Codes near the ends of the channel range.
  function automatic logic [7:0] edge_code();
    return $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1)) : 8'($urandom_range(0, 1));
  endfunction

  // Random pixel, weighted toward greys, ties and extreme codes.
  function automatic logic [IN_W-1:0] random_pixel();
    logic [7:0]  r, g, b, a;
    pixel_kind_t kind;
    int          roll;
    r    = 8'($urandom);
    g    = 8'($urandom);
    b    = 8'($urandom);
    a    = 8'($urandom);
    roll = $urandom_range(0, 14);
    kind = (roll < 7) ? PIX_ANY : pixel_kind_t'((roll - 7) % 5 + 1);
    case (kind)
      PIX_GREY: begin
        g = r;
        b = r;
      end
      PIX_TIE_RG: g = r;
      PIX_TIE_GB: b = g;
      PIX_TIE_RB: b = r;
      PIX_EXTREME: begin
        r = edge_code();
        g = edge_code();
        b = edge_code();
        a = edge_code();
      end
      default: ;
    endcase
    return pack_pixel(r, g, b, a);
  endfunction

  // Offer one pixel and hold it until the converter takes it.
  task automatic send_pixel(input logic [IN_W-1:0] pix);
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Pixel source: corner colors back to back, then random bursts and gaps.
  initial begin : source
    int burst_left;
    int gap;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(pack_pixel(8'd0,   8'd0,   8'd0,   8'd0));    // black
    send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 8'd255));  // white
    send_pixel(pack_pixel(8'd128, 8'd128, 8'd128, 8'h55));   // mid grey
    send_pixel(pack_pixel(8'd1,   8'd1,   8'd1,   8'hAA));   // darkest grey
    send_pixel(pack_pixel(8'd255, 8'd0,   8'd0,   8'd1));    // red, full saturation
    send_pixel(pack_pixel(8'd0,   8'd255, 8'd0,   8'd254));  // green
    send_pixel(pack_pixel(8'd0,   8'd0,   8'd255, 8'd128));  // blue
    send_pixel(pack_pixel(8'd255, 8'd255, 8'd0,   8'd127));  // red and green tie
    send_pixel(pack_pixel(8'd0,   8'd255, 8'd255, 8'd0));    // green and blue tie
    send_pixel(pack_pixel(8'd255, 8'd0,   8'd255, 8'd255));  // red and blue tie
    send_pixel(pack_pixel(8'd255, 8'd0,   8'd1,   8'd3));    // red max, hue wraps
    send_pixel(pack_pixel(8'd254, 8'd255, 8'd0,   8'd7));    // green max
    send_pixel(pack_pixel(8'd1,   8'd0,   8'd255, 8'd15));   // blue max
    send_pixel(pack_pixel(8'd1,   8'd0,   8'd0,   8'd31));   // dark, low lightness
    send_pixel(pack_pixel(8'd255, 8'd254, 8'd254, 8'd63));   // pale, high lightness
    send_pixel(pack_pixel(8'd128, 8'd127, 8'd0,   8'd191));  // sum of max and min is 128, below full code
    send_pixel(pack_pixel(8'd128, 8'd126, 8'd0,   8'd223));  // sum of max and min is 128, below full code
    send_pixel(pack_pixel(8'd0,   8'd0,   8'd1,   8'd239));  // faintest blue
    send_pixel(pack_pixel(8'd255, 8'd128, 8'd0,   8'd247));  // orange
    send_pixel(pack_pixel(8'd0,   8'd128, 8'd255, 8'd251));  // azure

    burst_left = $urandom_range(1, 32);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      send_pixel(random_pixel());
      burst_left--;
      if (burst_left == 0) begin
        // Most bursts end in a short gap; some run straight into the next one.
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(64, 160)
                                                : $urandom_range(1, 32);
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then give any stray result time to show up. The outstanding
    // count is registered, so it lags the checker's queue.
    do @(posedge clk); while (pending != 0);
    repeat (FRACTION_BITS + 16) @(posedge clk);

    $display("Run covered %0d pixels: corner colors (black, white, greys, primaries, ties,",
             results);
    $display("lightness boundary), then random bursts under output stalls and one long hold.");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result sink: stall patterns in random stretches, and one long hold-off
  // while the source keeps offering pixels.
  initial begin : sink
    ready_mode_t mode;
    int          stretch;
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && pixels_sent >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode    = ready_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(16, 128);
      repeat (stretch) begin
        case (mode)
          READY_ALWAYS: m_tready <= 1'b1;
          READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
          READY_MOSTLY: m_tready <= $urandom_range(0, 3) != 0;
          default:      m_tready <= $urandom_range(0, 3) == 0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Hard stop in case the pipeline hangs.
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rhc_pkg.sv
rtl/rhc_prep.sv
rtl/rhc_div_cell.sv
rtl/rgb_to_hsl_converter_core.sv
rtl/rhc_checker.sv
tb/rhc_checker.sv
tb/tb.sv
